FILE: rtl/core/b64e_pkg.sv
// Package for the Base64 stream encoder: job descriptor type, group phase
// codes, the pad character and the alphabet lookup. No dependencies.
`default_nettype none
package b64e_pkg;

   localparam logic [1:0] PhaseFirst  = 2'd0;
   localparam logic [1:0] PhaseSecond = 2'd1;
   localparam logic [1:0] PhaseThird  = 2'd2;

   localparam logic [7:0] PadChar = 8'h3D;

   // One accepted byte turns into a job of one to four characters.
   typedef struct packed {
      logic [3:0][5:0] sym;       // alphabet index per character slot
      logic [3:0]      pad;       // slot emits '=' instead of a symbol
      logic [1:0]      last_idx;  // index of the job's final slot
      logic            fin;       // job closes the message
   } job_type;

   function automatic logic [7:0] b64_char(input logic [5:0] idx);
      logic [7:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26) begin
         b64_char = 8'h41 + wide;
      end else if (idx < 6'd52) begin
         b64_char = 8'h61 + (wide - 8'd26);
      end else if (idx < 6'd62) begin
         b64_char = 8'h30 + (wide - 8'd52);
      end else if (idx == 6'd62) begin
         b64_char = 8'h2B;
      end else begin
         b64_char = 8'h2F;
      end
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/b64e_front.sv
// Front end of the Base64 encoder: accepts bytes, tracks the group phase and
// the carried bits, and builds one job per byte. Depends on b64e_pkg.
`default_nettype none
module b64e_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_final,
   input  wire logic             push_ready,
   output logic                  in_ready,
   output logic                  push_valid,
   output b64e_pkg::job_type     push_job
);
   import b64e_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       take;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign take       = in_valid && push_ready;

   always_comb begin
      push_job     = '0;
      push_job.fin = in_final;
      phase_in     = PhaseFirst;
      carry_in     = 4'd0;
      unique case (phase_ff)
         PhaseSecond: begin
            push_job.sym[0] = {carry_ff[1:0], in_byte[7:4]};
            if (in_final) begin
               push_job.sym[1]   = {in_byte[3:0], 2'b00};
               push_job.pad[2]   = 1'b1;
               push_job.last_idx = 2'd2;
            end else begin
               push_job.last_idx = 2'd0;
               carry_in          = in_byte[3:0];
               phase_in          = PhaseThird;
            end
         end
         PhaseThird: begin
            push_job.sym[0]   = {carry_ff, in_byte[7:6]};
            push_job.sym[1]   = in_byte[5:0];
            push_job.last_idx = 2'd1;
         end
         default: begin
            // An unused phase code acts as the start of a group.
            push_job.sym[0] = in_byte[7:2];
            if (in_final) begin
               push_job.sym[1]   = {in_byte[1:0], 4'b0000};
               push_job.pad[2]   = 1'b1;
               push_job.pad[3]   = 1'b1;
               push_job.last_idx = 2'd3;
            end else begin
               push_job.last_idx = 2'd0;
               carry_in          = {2'b00, in_byte[1:0]};
               phase_in          = PhaseSecond;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseFirst;
         carry_ff <= 4'd0;
      end else if (take) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/b64e_queue.sv
// Short job queue between the encoder's front and back ends.
// Register based ring buffer; depends on b64e_pkg for the job type.
`default_nettype none
module b64e_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire b64e_pkg::job_type push_job,
   output logic                  push_ready,
   output logic                  pop_valid,
   output b64e_pkg::job_type     pop_job,
   input  wire logic             pop
);
   import b64e_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

   job_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ff, rd_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != Full);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/b64e_back.sv
// Back end of the Base64 encoder: walks the character slots of the head job
// and drives the registered output transfer. Depends on b64e_pkg.
`default_nettype none
module b64e_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire b64e_pkg::job_type job,
   output logic                  job_pop,
   output logic                  out_valid,
   output logic [7:0]            out_char,
   output logic                  out_last,
   input  wire logic             out_ready
);
   import b64e_pkg::*;

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load, at_end;

   assign load    = job_valid && (!valid_ff || out_ready);
   assign at_end  = (idx_ff == job.last_idx);
   assign job_pop = load && at_end;
   assign char_in = job.pad[idx_ff] ? PadChar : b64_char(job.sym[idx_ff]);
   assign last_in = job.fin && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff <= at_end ? 2'd0 : idx_ff + 2'd1;
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule
`default_nettype wire

FILE: rtl/core/base64_stream_encoder.sv
// Top level of the Base64 stream encoder (RFC 4648 alphabet, '=' padded).
// Instantiates b64e_front, b64e_queue and b64e_back; depends on b64e_pkg.
//
// Usage:
//   Bytes enter on the req_ stream, one per transfer; req_tlast marks the
//   final byte of a message. Characters leave on the rsp_ stream, one per
//   transfer, as ASCII codes; rsp_tlast marks the final character of the
//   encoded message, which already includes any '=' padding.
//   A byte yields one, one or two characters at the first, second and third
//   position of its 3-byte group; a final byte yields four, three or two.
//   The output delivers one character per cycle while rsp_tready is high,
//   which sets the pace of byte intake. Each byte's job is first written
//   into the queue; the back end then registers the job's first character
//   in its output register before that character leaves on the rsp_ stream.
//   The front end decodes each byte into a job in the same cycle that it is
//   accepted; a queue of QUEUE_DEPTH jobs lets it keep taking bytes while
//   the back end is still emitting earlier characters or is stalled by the
//   receiver. When rsp_tready is low the registered output holds, the queue
//   fills, and req_tready drops once it is full; nothing is lost.
//   Reset returns the encoder to the start of a group and empties the queue.
//   QUEUE_DEPTH is meant to stay between 2 and 16.
`default_nettype none
module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // final_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic            rsp_tlast    // last_char
);
   import b64e_pkg::*;

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop;
   job_type pop_job;

   // Front end: phase tracking and job building.
   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_final   (req_tlast),
      .push_ready (push_ready),
      .in_ready   (req_tready),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // Job queue that decouples byte intake from character output.
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   // Back end: one character per transfer from a registered output.
   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_job),
      .job_pop   (pop),
      .out_valid (rsp_tvalid),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

endmodule
`default_nettype wire

FILE: test/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_encoder: byte messages go in on the
// req_ stream and every Base64 character on rsp_ is checked against a predictor.
// Depends on b64e_pkg and the encoder RTL.
module base64_stream_encoder_tb;
   import b64e_pkg::*;

   localparam int CycleLimit   = 300000;
   localparam int RandomItems  = 360;
   localparam int SettleCycles = 16;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } b64_symbol_type;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_MOSTLY} rx_mode_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] data_byte
   logic       req_tlast  = 1'b0;    // final_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_char
   logic       rsp_tlast;            // last_char

   // Characters predicted for accepted bytes, oldest first.
   b64_symbol_type pending_chars[$];
   b64_symbol_type rx_want;

   // Predictor state: position in the 3-byte group and the unused low bits.
   logic [1:0] enc_phase = PhaseFirst;
   logic [3:0] enc_carry = 4'h0;
   string      char_table =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // Sender burst control.
   int  burst_left    = 4;
   bit  sender_steady = 1'b0;
   bit  offering      = 1'b0;

   // Receiver control: the tests write mode, pattern and hold requests; the
   // receiver process owns everything it counts.
   rx_mode_type rx_mode   = RX_ALWAYS;
   logic [7:0] rx_pattern = 8'hB5;
   logic [2:0] rx_bit     = 3'd0;
   int         hold_len   = 0;
   int         hold_id    = 0;
   int         hold_id_seen = 0;
   int         hold_left  = 0;
   bit         ready_next;

   // Statistics and failure accounting.
   int cycle_count    = 0;
   int mismatch_count = 0;
   int bytes_sent     = 0;
   int messages_sent  = 0;
   int chars_checked  = 0;
   int pads_checked   = 0;
   int input_stalls   = 0;
   int finals_at[3]   = '{0, 0, 0};

   base64_stream_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog and input backpressure statistics.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_tvalid && req_tready === 1'b0) begin
         input_stalls <= input_stalls + 1;
      end
      if (cycle_count >= CycleLimit) begin
         $display("Watchdog expired after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH (cycle %0d): %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic void push_char(input logic [7:0] code, input logic last);
      b64_symbol_type s;
      s.code = code;
      s.last = last;
      pending_chars = {pending_chars, s};
   endfunction

   function automatic logic [7:0] sextet_char(input logic [5:0] six);
      return char_table[six];
   endfunction

   // Work out the characters that one accepted byte completes and advance
   // the group position. A final byte closes the group with '=' padding.
   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      if (fin) begin
         finals_at[(enc_phase == PhaseSecond) ? 1 : (enc_phase == PhaseThird) ? 2 : 0]++;
      end
      case (enc_phase)
         PhaseSecond: begin
            // Only the two bits left by the first byte take part here.
            push_char(sextet_char({enc_carry[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               push_char(sextet_char({b[3:0], 2'b00}), 1'b0);
               push_char(PadChar, 1'b1);
               enc_phase = PhaseFirst;
               enc_carry = 4'h0;
            end else begin
               enc_carry = b[3:0];
               enc_phase = PhaseThird;
            end
         end
         PhaseThird: begin
            push_char(sextet_char({enc_carry, b[7:6]}), 1'b0);
            push_char(sextet_char(b[5:0]), fin);
            enc_phase = PhaseFirst;
            enc_carry = 4'h0;
         end
         default: begin
            push_char(sextet_char(b[7:2]), 1'b0);
            if (fin) begin
               push_char(sextet_char({b[1:0], 4'h0}), 1'b0);
               push_char(PadChar, 1'b0);
               push_char(PadChar, 1'b1);
               enc_phase = PhaseFirst;
               enc_carry = 4'h0;
            end else begin
               enc_carry = {2'b00, b[1:0]};
               enc_phase = PhaseSecond;
            end
         end
      endcase
   endfunction

   // Offer one byte, wait for its transfer, then predict. Called in the time
   // step of a rising edge. tvalid stays high into the next byte unless the
   // burst ends, so it is never lowered and raised in one step.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      offering = 1'b1;
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      encode_byte(b, fin);
      bytes_sent++;
      if (fin) begin
         messages_sent++;
      end
      if (!sender_steady) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_tvalid <= 1'b0;
            offering = 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 3);
            repeat (gap) @(posedge clock);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 8);
         end
      end
   endtask

   // Stop offering and wait until every predicted character has been seen.
   task automatic wait_drained;
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte;
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h01 << $urandom_range(0, 7);
         3:       return ~(8'h01 << $urandom_range(0, 7));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Receiver: checks each character transfer and drives tready from the
   // current stall mode. A long hold-off request overrides the mode.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               rx_want = pending_chars.pop_front();
               if (rsp_tdata !== rx_want.code) begin
                  report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                            rsp_tdata, rx_want.code));
               end
               if (rsp_tlast !== rx_want.last) begin
                  report_mismatch($sformatf("last_char %0b, expected %0b (char 0x%02h)",
                                            rsp_tlast, rx_want.last, rx_want.code));
               end
               chars_checked++;
               if (rx_want.code == PadChar) begin
                  pads_checked++;
               end
            end
         end
         if (hold_id != hold_id_seen) begin
            hold_id_seen = hold_id;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS:  ready_next = 1'b1;
               RX_RANDOM:  ready_next = 1'($urandom_range(0, 1));
               RX_PATTERN: ready_next = rx_pattern[rx_bit];
               default:    ready_next = ($urandom_range(0, 7) != 0);
            endcase
         end
         rx_bit = rx_bit + 3'd1;
         rsp_tready <= ready_next;
      end
   end

   // Short messages closing at each group position, with all-zero and
   // all-one bytes, the '+' and '/' symbols and a multi-group message.
   task automatic test_directed_vectors;
      logic [8:0] vec [24];
      vec = '{9'h100, 9'h1FF,
              9'h000, 9'h1FF,
              9'h0FF, 9'h100,
              9'h000, 9'h000, 9'h100,
              9'h0FF, 9'h0FF, 9'h1FF,
              9'h0FB, 9'h0EF, 9'h1BE,
              9'h04D, 9'h061, 9'h06E, 9'h14D,
              9'h055, 9'h0AA, 9'h055, 9'h0AA, 9'h155};
      rx_mode = RX_RANDOM;
      foreach (vec[i]) begin
         send_byte(vec[i][7:0], vec[i][8]);
      end
      wait_drained();
   endtask

   // Random messages of mostly short length; sender bursts and receiver
   // stall mode change from message to message.
   task automatic test_random_messages;
      int sent;
      int len;
      sent = 0;
      while (sent < RandomItems) begin
         case ($urandom_range(0, 19))
            0:       len = $urandom_range(25, 60);
            1, 2, 3: len = $urandom_range(9, 24);
            default: len = $urandom_range(1, 8);
         endcase
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_pattern = 8'($urandom_range(1, 255));
         sender_steady = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), i == len - 1);
         end
         sent += len;
      end
      sender_steady = 1'b0;
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the job queue fills and the encoder stalls its input.
   task automatic test_output_hold_off;
      rx_mode = RX_ALWAYS;
      sender_steady = 1'b1;
      hold_len = 150;
      hold_id++;
      for (int i = 0; i < 32; i++) begin
         send_byte(pick_byte(), i == 9 || i == 20 || i == 31);
      end
      sender_steady = 1'b0;
      wait_drained();
   endtask

   // The sender waits for the output to run dry after every message.
   task automatic test_drain_between_messages;
      rx_mode = RX_MOSTLY;
      for (int m = 1; m <= 6; m++) begin
         for (int i = 0; i < m; i++) begin
            send_byte(pick_byte(), i == m - 1);
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_vectors();
      test_random_messages();
      test_output_hold_off();
      test_drain_between_messages();
      // Let any stray character show up before the verdict.
      repeat (SettleCycles) @(posedge clock);
      if (pending_chars.size() != 0) begin
         report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
      end
      $display("Encoded %0d bytes in %0d messages, checked %0d characters (%0d pads).",
               bytes_sent, messages_sent, chars_checked, pads_checked);
      $display("Messages ended at group byte 1/2/3: %0d/%0d/%0d; input stalled %0d cycles.",
               finals_at[0], finals_at[1], finals_at[2], input_stalls);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
